FILE: hw/rtl/mmrs_pkg.sv
// shared codes and widths for the masked match record set
package mmrs_pkg;

    localparam int FUNC_W   = 3;
    localparam int STATUS_W = 2;
    localparam int WORD_W   = 64;
    localparam int RID_W    = 16;
    localparam int POS_W    = 8;
    localparam int MCNT_W   = 9;
    localparam int CFG_IDX_W = 1;

    typedef logic [FUNC_W-1:0]    t_func;
    typedef logic [STATUS_W-1:0]  t_status;
    typedef logic [WORD_W-1:0]    t_word;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_func FUNC_INSERT = 3'd0;
    localparam t_func FUNC_DELETE = 3'd1;
    localparam t_func FUNC_CHANGE = 3'd2;
    localparam t_func FUNC_READ   = 3'd3;
    localparam t_func FUNC_ERASE  = 3'd4;

    localparam t_status STATUS_OK      = 2'd0;
    localparam t_status STATUS_MISSING = 2'd1;
    localparam t_status STATUS_FULL    = 2'd2;
    localparam t_status STATUS_BAD_POS = 2'd3;

    localparam t_cfg_idx CFG_MATCH_MASK  = 1'b0;
    localparam t_cfg_idx CFG_MATCH_VALUE = 1'b1;

endpackage

FILE: hw/rtl/mmrs_ram.sv
// single write port, single registered read port identifier memory
module mmrs_ram #(
    parameter int DEPTH = 256,
    parameter int AW    = 8,
    parameter int DW    = 16
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hw/rtl/masked_match_record_set_core.sv
// masked match record set: sequencer, match compare and member list control
//
// Usage: configure match_mask (index 0) and match_value (index 1) through the
// write port while idle. Issue a transaction by raising start while busy is
// low; func, record_id, new_word, old_word and position are sampled at that
// edge. busy stays high until the result is presented: o_strobe pulses for
// exactly one cycle with status, member count, entry record, entry valid and
// set changed. The receiver cannot stall; a new start may be given in the
// strobe cycle.
// From accept to strobe: insert passes decode and append; read passes decode,
// position read and position capture; erase adds move read and move write;
// ignored or non-matching ops, full list, empty list removal and bad position
// end in decode. A removal searches the list one entry at a time through the
// single memory read port, then moves the last entry into the found slot.
// Reset (synchronous, active low) empties the list and clears both match
// registers; list memory contents are left as they are.
module masked_match_record_set_core #(
    parameter int LIST_DEPTH = 256,
    parameter int ID_WIDTH   = 16
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  mmrs_pkg::t_cfg_idx       i_cfg_addr,
    input  mmrs_pkg::t_word          i_cfg_wdata,
    input  logic                     start,
    output logic                     busy,
    input  mmrs_pkg::t_func          i_func,
    input  logic [15:0]              i_record_id,
    input  mmrs_pkg::t_word          i_new_word,
    input  mmrs_pkg::t_word          i_old_word,
    input  logic [7:0]               i_position,
    output logic                     o_strobe,
    output mmrs_pkg::t_status        o_status,
    output logic [8:0]               o_member_count,
    output logic [15:0]              o_entry_record,
    output logic                     o_entry_valid,
    output logic                     o_set_changed
);
    import mmrs_pkg::*;

    localparam int AW    = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam int CNT_W = $clog2(LIST_DEPTH + 1);
    localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;
    localparam int MC_W  = (CNT_W > MCNT_W) ? CNT_W : MCNT_W;
    localparam int IDX_W = (ID_WIDTH > RID_W) ? ID_WIDTH : RID_W;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_APPEND,
        S_SRCH_RD,
        S_SRCH_CMP,
        S_POS_RD,
        S_POS_CAP,
        S_MOVE_RD,
        S_MOVE_WR
    } t_state;

    t_state              r_state;
    t_word               r_mask;
    t_word               r_value;
    t_func               r_func;
    logic [ID_WIDTH-1:0] r_id;
    t_word               r_nw;
    t_word               r_ow;
    logic [POS_W-1:0]    r_pos;
    logic [CNT_W-1:0]    r_count;
    logic [AW-1:0]       r_idx;
    logic [ID_WIDTH-1:0] r_rec;
    t_status             r_status;
    logic                r_valid;
    logic                r_changed;
    logic                r_strobe;

    logic                w_now;
    logic                w_was;
    logic                w_add;
    logic                w_remove;
    logic                w_full;
    logic                w_hit;
    logic [CMP_W-1:0]    w_pos_ext;
    logic [CMP_W-1:0]    w_cnt_ext;
    logic                w_pos_ok;
    logic [CNT_W-1:0]    w_last;
    logic [IDX_W-1:0]    w_id_ext;
    logic [IDX_W-1:0]    w_rec_ext;
    logic [MC_W-1:0]     w_cnt_out;

    logic                w_we;
    logic [AW-1:0]       w_waddr;
    logic [ID_WIDTH-1:0] w_wdata;
    logic                w_re;
    logic [AW-1:0]       w_raddr;
    logic [ID_WIDTH-1:0] w_rdata;

    assign w_now     = (r_nw & r_mask) == r_value;
    assign w_was     = (r_ow & r_mask) == r_value;
    assign w_add     = ((r_func == FUNC_INSERT) && w_now)
                     || ((r_func == FUNC_CHANGE) && w_now && !w_was);
    assign w_remove  = ((r_func == FUNC_DELETE) && w_was)
                     || ((r_func == FUNC_CHANGE) && !w_now && w_was);
    assign w_full    = r_count == CNT_W'(LIST_DEPTH);
    assign w_hit     = w_rdata == r_id;
    assign w_pos_ext = CMP_W'(r_pos);
    assign w_cnt_ext = CMP_W'(r_count);
    assign w_pos_ok  = w_pos_ext < w_cnt_ext;
    assign w_last    = r_count - CNT_W'(1);
    assign w_id_ext  = IDX_W'(i_record_id);
    assign w_rec_ext = IDX_W'(r_rec);
    assign w_cnt_out = MC_W'(r_count);

    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_idx;
        w_wdata = w_rdata;
        w_re    = 1'b0;
        w_raddr = r_idx;
        unique case (r_state)
            S_APPEND: begin
                w_we    = 1'b1;
                w_waddr = r_count[AW-1:0];
                w_wdata = r_id;
            end
            S_SRCH_RD: begin
                w_re    = 1'b1;
            end
            S_POS_RD: begin
                w_re    = 1'b1;
                w_raddr = w_pos_ext[AW-1:0];
            end
            S_MOVE_RD: begin
                w_re    = 1'b1;
                w_raddr = w_last[AW-1:0];
            end
            S_MOVE_WR: begin
                w_we    = 1'b1;
            end
            default: begin
            end
        endcase
    end

    mmrs_ram #(
        .DEPTH (LIST_DEPTH),
        .AW    (AW),
        .DW    (ID_WIDTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask  <= '0;
            r_value <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_MATCH_MASK:  r_mask  <= i_cfg_wdata;
                CFG_MATCH_VALUE: r_value <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_strobe  <= 1'b0;
            r_idx     <= '0;
            r_status  <= STATUS_OK;
            r_valid   <= 1'b0;
            r_changed <= 1'b0;
            r_rec     <= '0;
        end else begin
            r_strobe <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_func  <= i_func;
                        r_id    <= w_id_ext[ID_WIDTH-1:0];
                        r_nw    <= i_new_word;
                        r_ow    <= i_old_word;
                        r_pos   <= i_position;
                        r_state <= S_DECODE;
                    end
                end
                S_DECODE: begin
                    r_status  <= STATUS_OK;
                    r_valid   <= 1'b0;
                    r_changed <= 1'b0;
                    r_rec     <= '0;
                    r_idx     <= '0;
                    if (w_add) begin
                        if (w_full) begin
                            r_status <= STATUS_FULL;
                            r_strobe <= 1'b1;
                            r_state  <= S_IDLE;
                        end else begin
                            r_state <= S_APPEND;
                        end
                    end else if (w_remove) begin
                        if (r_count == '0) begin
                            r_status <= STATUS_MISSING;
                            r_strobe <= 1'b1;
                            r_state  <= S_IDLE;
                        end else begin
                            r_state <= S_SRCH_RD;
                        end
                    end else if (r_func == FUNC_READ || r_func == FUNC_ERASE) begin
                        if (w_pos_ok) begin
                            r_state <= S_POS_RD;
                        end else begin
                            r_status <= STATUS_BAD_POS;
                            r_strobe <= 1'b1;
                            r_state  <= S_IDLE;
                        end
                    end else begin
                        r_strobe <= 1'b1;
                        r_state  <= S_IDLE;
                    end
                end
                S_APPEND: begin
                    r_count   <= r_count + CNT_W'(1);
                    r_changed <= 1'b1;
                    r_strobe  <= 1'b1;
                    r_state   <= S_IDLE;
                end
                S_SRCH_RD: begin
                    r_state <= S_SRCH_CMP;
                end
                S_SRCH_CMP: begin
                    if (w_hit) begin
                        r_state <= S_MOVE_RD;
                    end else if (CNT_W'(r_idx) == w_last) begin
                        r_status <= STATUS_MISSING;
                        r_strobe <= 1'b1;
                        r_state  <= S_IDLE;
                    end else begin
                        r_idx   <= r_idx + AW'(1);
                        r_state <= S_SRCH_RD;
                    end
                end
                S_POS_RD: begin
                    r_state <= S_POS_CAP;
                end
                S_POS_CAP: begin
                    r_rec   <= w_rdata;
                    r_valid <= 1'b1;
                    r_idx   <= w_pos_ext[AW-1:0];
                    if (r_func == FUNC_ERASE) begin
                        r_state <= S_MOVE_RD;
                    end else begin
                        r_strobe <= 1'b1;
                        r_state  <= S_IDLE;
                    end
                end
                S_MOVE_RD: begin
                    r_state <= S_MOVE_WR;
                end
                S_MOVE_WR: begin
                    r_count   <= w_last;
                    r_changed <= 1'b1;
                    r_strobe  <= 1'b1;
                    r_state   <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign busy           = r_state != S_IDLE;
    assign o_strobe       = r_strobe;
    assign o_status       = r_status;
    assign o_member_count = w_cnt_out[MCNT_W-1:0];
    assign o_entry_record = w_rec_ext[RID_W-1:0];
    assign o_entry_valid  = r_valid;
    assign o_set_changed  = r_changed;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(LIST_DEPTH))
        else $error("member count beyond list depth");

    a_strobe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_strobe |-> (r_state == S_IDLE))
        else $error("result strobe while sequencer busy");

    a_start_decode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (r_state == S_DECODE))
        else $error("accepted transaction not decoded");

    a_changed_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_strobe && r_changed) |-> (r_status == STATUS_OK))
        else $error("set changed with failing status");

    a_changed_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_strobe && r_changed) |-> (r_count != $past(r_count)))
        else $error("set changed without count update");

    a_valid_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_strobe && r_valid) |-> (r_func == FUNC_READ || r_func == FUNC_ERASE))
        else $error("entry valid on a non positional transaction");
`endif

endmodule

FILE: bench/tb.sv
// testbench for masked_match_record_set_core: directed and random list traffic against a predictor
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mmrs_pkg::*;

    localparam int LIST_DEPTH  = 256;
    localparam int STALL_LIMIT = 4000;
    localparam int PHASE_ITEMS = 150;

    typedef struct packed {
        t_status     status;
        logic [8:0]  count;
        logic [15:0] rec;
        logic        valid;
        logic        changed;
    } t_outcome;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    t_cfg_idx    i_cfg_addr = CFG_MATCH_MASK;
    t_word       i_cfg_wdata = '0;
    logic        start = 1'b0;
    logic        busy;
    t_func       i_func = FUNC_INSERT;
    logic [15:0] i_record_id = '0;
    t_word       i_new_word = '0;
    t_word       i_old_word = '0;
    logic [7:0]  i_position = '0;
    logic        o_strobe;
    t_status     o_status;
    logic [8:0]  o_member_count;
    logic [15:0] o_entry_record;
    logic        o_entry_valid;
    logic        o_set_changed;

    // predictor state
    logic [15:0] members [LIST_DEPTH];
    int unsigned member_total = 0;
    t_word       mask_copy = '0;
    t_word       value_copy = '0;
    t_outcome    outcomes_due [$];

    int          fail_count = 0;
    int unsigned idle_pct = 0;
    int unsigned stall_cycles = 0;

    masked_match_record_set_core uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_addr     (i_cfg_addr),
        .i_cfg_wdata    (i_cfg_wdata),
        .start          (start),
        .busy           (busy),
        .i_func         (i_func),
        .i_record_id    (i_record_id),
        .i_new_word     (i_new_word),
        .i_old_word     (i_old_word),
        .i_position     (i_position),
        .o_strobe       (o_strobe),
        .o_status       (o_status),
        .o_member_count (o_member_count),
        .o_entry_record (o_entry_record),
        .o_entry_valid  (o_entry_valid),
        .o_set_changed  (o_set_changed)
    );

    always #4 i_clk = ~i_clk;

    function automatic bit key_hit(t_word w);
        return (w & mask_copy) == value_copy;
    endfunction

    function automatic bit append_member(logic [15:0] id);
        if (member_total >= LIST_DEPTH) return 1'b0;
        members[member_total] = id;
        member_total++;
        return 1'b1;
    endfunction

    function automatic void erase_member(int unsigned pos);
        member_total--;
        members[pos] = members[member_total];
    endfunction

    function automatic bit remove_member(logic [15:0] id);
        for (int unsigned k = 0; k < member_total; k++) begin
            if (members[k] == id) begin
                erase_member(k);
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    function automatic t_outcome list_op_outcome(t_func f, logic [15:0] id, t_word nw,
                                                 t_word ow, logic [7:0] pos);
        t_outcome r;
        bit       now_hit;
        bit       was_hit;
        r = '0;
        now_hit = key_hit(nw);
        was_hit = key_hit(ow);
        case (f)
            FUNC_INSERT: begin
                if (now_hit) begin
                    if (append_member(id)) r.changed = 1'b1;
                    else r.status = STATUS_FULL;
                end
            end
            FUNC_DELETE: begin
                if (was_hit) begin
                    if (remove_member(id)) r.changed = 1'b1;
                    else r.status = STATUS_MISSING;
                end
            end
            FUNC_CHANGE: begin
                if (now_hit && !was_hit) begin
                    if (append_member(id)) r.changed = 1'b1;
                    else r.status = STATUS_FULL;
                end else if (!now_hit && was_hit) begin
                    if (remove_member(id)) r.changed = 1'b1;
                    else r.status = STATUS_MISSING;
                end
            end
            FUNC_READ: begin
                if (pos < member_total) begin
                    r.rec   = members[pos];
                    r.valid = 1'b1;
                end else begin
                    r.status = STATUS_BAD_POS;
                end
            end
            FUNC_ERASE: begin
                if (pos < member_total) begin
                    r.rec     = members[pos];
                    r.valid   = 1'b1;
                    r.changed = 1'b1;
                    erase_member(pos);
                end else begin
                    r.status = STATUS_BAD_POS;
                end
            end
            default: ;
        endcase
        r.count = member_total[8:0];
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch in %s at %0t: got %0h, expected %0h", what, $time, got, want);
        fail_count++;
    endtask

    // result checker
    always @(posedge i_clk) begin
        t_outcome want;
        if (i_rst_n && o_strobe === 1'b1) begin
            if (outcomes_due.size() == 0) begin
                report_mismatch("unexpected transaction", 64'(o_member_count), 64'd0);
            end else begin
                want = outcomes_due.pop_front();
                if (o_status !== want.status)
                    report_mismatch("status", 64'(o_status), 64'(want.status));
                if (o_member_count !== want.count)
                    report_mismatch("member_count", 64'(o_member_count), 64'(want.count));
                if (o_entry_record !== want.rec)
                    report_mismatch("entry_record", 64'(o_entry_record), 64'(want.rec));
                if (o_entry_valid !== want.valid)
                    report_mismatch("entry_valid", 64'(o_entry_valid), 64'(want.valid));
                if (o_set_changed !== want.changed)
                    report_mismatch("set_changed", 64'(o_set_changed), 64'(want.changed));
            end
        end
    end

    // watchdog on cycles with no transaction moving
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_strobe === 1'b1) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("watchdog expired at %0t", $time);
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    task automatic issue_op(t_func f, logic [15:0] id, t_word nw, t_word ow, logic [7:0] pos);
        while ($urandom_range(99) < idle_pct) begin
            @(negedge i_clk);
            start = 1'b0;
        end
        @(negedge i_clk);
        start       = 1'b1;
        i_func      = f;
        i_record_id = id;
        i_new_word  = nw;
        i_old_word  = ow;
        i_position  = pos;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        outcomes_due.push_back(list_op_outcome(f, id, nw, ow, pos));
    endtask

    task automatic settle();
        @(negedge i_clk);
        start = 1'b0;
        while (outcomes_due.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, t_word val);
        @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_addr  = idx;
        i_cfg_wdata = val;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        if (idx == CFG_MATCH_MASK) mask_copy = val;
        else value_copy = val;
    endtask

    task automatic set_match(t_word m, t_word v);
        settle();
        write_reg(CFG_MATCH_MASK, m);
        write_reg(CFG_MATCH_VALUE, v);
    endtask

    function automatic t_word rand_word();
        return {$urandom, $urandom};
    endfunction

    // a hit is only possible when the value has no bits outside the mask
    function automatic t_word key_word(bit hit);
        if (hit) return (rand_word() & ~mask_copy) | value_copy;
        return rand_word();
    endfunction

    function automatic bit rand_hit();
        return 1'($urandom_range(1));
    endfunction

    function automatic logic [7:0] rand_pos();
        return 8'($urandom_range(255));
    endfunction

    function automatic logic [15:0] pick_id(int unsigned pct_known);
        if (member_total > 0 && $urandom_range(99) < pct_known)
            return members[$urandom_range(member_total - 1)];
        return 16'($urandom_range(16'hFFFF));
    endfunction

    function automatic logic [7:0] pick_pos();
        if (member_total > 0 && $urandom_range(99) < 70)
            return 8'($urandom_range(member_total - 1));
        return rand_pos();
    endfunction

    task automatic random_op();
        int unsigned sel;
        sel = $urandom_range(99);
        if (sel < 30)
            issue_op(FUNC_INSERT, pick_id(15), key_word(rand_hit()), rand_word(),
                     rand_pos());
        else if (sel < 50)
            issue_op(FUNC_DELETE, pick_id(70), rand_word(), key_word(rand_hit()),
                     rand_pos());
        else if (sel < 70)
            issue_op(FUNC_CHANGE, pick_id(60), key_word(rand_hit()),
                     key_word(rand_hit()), rand_pos());
        else if (sel < 85)
            issue_op(FUNC_READ, pick_id(20), rand_word(), rand_word(), pick_pos());
        else if (sel < 95)
            issue_op(FUNC_ERASE, pick_id(20), rand_word(), rand_word(), pick_pos());
        else
            issue_op(t_func'($urandom_range(7, 5)), pick_id(50), rand_word(), rand_word(),
                     rand_pos());
    endtask

    // reset config: zero mask and value, so every word matches
    task automatic test_empty_list();
        idle_pct = 0;
        issue_op(FUNC_READ, 16'h0000, '0, '0, 8'd0);
        issue_op(FUNC_ERASE, 16'h0000, '0, '0, 8'd255);
        issue_op(FUNC_DELETE, 16'h0005, '0, '0, 8'd0);
        for (int k = 5; k <= 7; k++)
            issue_op(t_func'(k), 16'hFFFF, '1, '1, 8'hFF);
        issue_op(FUNC_INSERT, 16'hFFFF, '1, '0, 8'd0);
        issue_op(FUNC_INSERT, 16'h0000, '0, '1, 8'd0);
        issue_op(FUNC_CHANGE, 16'h0000, '1, '0, 8'd0);
        issue_op(FUNC_READ, 16'h0000, '0, '0, 8'd1);
        issue_op(FUNC_READ, 16'h0000, '0, '0, 8'd2);
    endtask

    task automatic test_match_rules();
        t_word v;
        v = 64'hA5A5_5A5A_0F0F_F0F0;
        set_match('1, v);
        idle_pct = 46;
        issue_op(FUNC_INSERT, 16'h1234, ~v, v, 8'd0);
        issue_op(FUNC_INSERT, 16'h1234, v, ~v, 8'd0);
        issue_op(FUNC_INSERT, 16'h1234, v, ~v, 8'd0);
        issue_op(FUNC_CHANGE, 16'hBEEF, v, ~v, 8'd0);
        issue_op(FUNC_CHANGE, 16'h1234, ~v, v, 8'd0);
        issue_op(FUNC_CHANGE, 16'h4321, ~v, ~v, 8'd0);
        issue_op(FUNC_CHANGE, 16'h4321, v, v, 8'd0);
        issue_op(FUNC_DELETE, 16'hFFFF, v, ~v, 8'd0);
        issue_op(FUNC_DELETE, 16'hFFFF, ~v, v, 8'd0);
        issue_op(FUNC_DELETE, 16'h7777, ~v, v, 8'd0);
        issue_op(FUNC_CHANGE, 16'h7777, ~v, v, 8'd0);
        issue_op(FUNC_ERASE, 16'h0000, '0, '0, 8'd0);
        issue_op(FUNC_READ, 16'h0000, '0, '0, 8'd1);
        issue_op(FUNC_READ, 16'h0000, '1, '1, 8'd255);
    endtask

    task automatic test_full_list();
        t_word       m;
        t_word       hit_w;
        int unsigned sel;
        m = rand_word() | 64'h1;
        set_match(m, rand_word() & m);
        idle_pct = 10;
        while (member_total < LIST_DEPTH)
            issue_op(FUNC_INSERT, pick_id(10), key_word(1'b1), rand_word(), rand_pos());
        hit_w = key_word(1'b1);
        issue_op(FUNC_INSERT, pick_id(0), hit_w, rand_word(), 8'd0);
        issue_op(FUNC_CHANGE, pick_id(0), hit_w, hit_w ^ 64'h1, 8'd0);
        issue_op(FUNC_INSERT, pick_id(0), hit_w ^ 64'h1, hit_w, 8'd0);
        issue_op(FUNC_READ, 16'h0000, '0, '0, 8'd255);
        issue_op(FUNC_ERASE, 16'h0000, '0, '0, 8'd255);
        issue_op(FUNC_READ, 16'h0000, '0, '0, 8'd255);
        // hold off until the list is quiet before the cursor walk
        settle();
        idle_pct = 46;
        while (member_total > 0) begin
            sel = $urandom_range(99);
            if (sel < 60)
                issue_op(FUNC_ERASE, pick_id(0), rand_word(), rand_word(), 8'd0);
            else if (sel < 80)
                issue_op(FUNC_ERASE, pick_id(0), rand_word(), rand_word(), pick_pos());
            else if (sel < 90)
                issue_op(FUNC_READ, pick_id(0), rand_word(), rand_word(), pick_pos());
            else
                issue_op(FUNC_DELETE, pick_id(90), rand_word(), key_word(1'b1),
                         rand_pos());
        end
    endtask

    task automatic test_random_traffic();
        t_word m;
        t_word v;
        for (int phase = 0; phase < 7; phase++) begin
            case (phase)
                0: begin m = '0; v = '0; idle_pct = 0; end
                1: begin m = '1; v = rand_word(); idle_pct = 46; end
                2: begin m = rand_word(); v = rand_word() & m; idle_pct = 10; end
                3: begin
                    // value bit outside the mask: nothing can match
                    m = rand_word() & 64'h7FFF_FFFF_FFFF_FFFF;
                    v = rand_word() | 64'h8000_0000_0000_0000;
                    idle_pct = 46;
                end
                4: begin m = '0; v = '1; idle_pct = 0; end
                5: begin m = '1; v = '1; idle_pct = 10; end
                default: begin
                    m = rand_word() & rand_word() & rand_word();
                    v = rand_word() & m;
                    idle_pct = 46;
                end
            endcase
            set_match(m, v);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if ($urandom_range(99) < 3) settle();
                random_op();
            end
        end
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        test_empty_list();
        test_match_rules();
        test_full_list();
        test_random_traffic();
        settle();
        repeat (20) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

FILE: files.f
hw/rtl/mmrs_pkg.sv
hw/rtl/mmrs_ram.sv
hw/rtl/masked_match_record_set_core.sv
bench/tb.sv
